@@ design/graph_eccentricity_engine_unit_macros.svh @@
// assertion macros for the graph eccentricity engine
`ifndef GRAPH_ECCENTRICITY_ENGINE_UNIT_MACROS_SVH
`define GRAPH_ECCENTRICITY_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GEE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gee assertion failed");
`define GEE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gee assertion failed");
`else
`define GEE_ASSERT_IMP(lbl, ante, cons)
`define GEE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ design/gee_pkg.sv @@
// shared types and constants for the graph eccentricity engine
`default_nettype none
package gee_pkg;
    localparam int NumVert  = 16;
    localparam int VertW    = 4;
    localparam int DistW    = 10;
    localparam int WeightW  = 4;
    localparam int CountW   = 5;
    localparam logic [DistW-1:0] DistMax = 10'd1023;
    localparam logic [CountW-1:0] VcReset = 5'd16;
    localparam logic OpWrite   = 1'b0;
    localparam logic OpCompute = 1'b1;

    typedef struct packed {
        logic               op;
        logic [VertW-1:0]   row;
        logic [VertW-1:0]   col;
        logic [WeightW-1:0] weight;
    } in_t;

    typedef struct packed {
        logic [VertW-1:0] vertex;
        logic [DistW-1:0] eccentricity;
        logic [DistW-1:0] radius;
        logic [DistW-1:0] diameter;
        logic             is_central;
        logic             is_peripheral;
        logic             is_isolated;
        logic             reaches_all;
        logic             reaches_two;
        logic             last;
    } out_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic              init;
        logic              relax;
        logic              red_en;
        logic              store;
        logic              sum_clr;
        logic              sum_en;
        logic              emit;
        logic              last;
        logic [VertW-1:0]  rd_row;
        logic [VertW-1:0]  idx;
        logic [VertW-1:0]  src;
        logic [CountW-1:0] n;
    } cmd_t;
endpackage
`default_nettype wire

@@ design/gee_dp.sv @@
// datapath: adjacency memory, relaxation lanes, reductions and output register
`default_nettype none
module gee_dp (
    input  wire logic          aclk,
    input  wire gee_pkg::in_t  s_data,
    input  wire gee_pkg::cmd_t cmd,
    output gee_pkg::out_t      m_data
);
    import gee_pkg::*;

    logic [NumVert*WeightW-1:0] adj_mem [NumVert];
    logic [NumVert*WeightW-1:0] adj_q_reg;
    logic [DistW-1:0] dist_reg [NumVert];
    logic [DistW-1:0] dist_next [NumVert];
    logic [NumVert-1:0] reach_reg, reach_next;
    logic [DistW-1:0] max_reg;
    logic [CountW-1:0] cnt_reg;
    logic [DistW-1:0] ecc_store [NumVert];
    logic [NumVert-1:0] full_reg, two_reg;
    logic [DistW-1:0] radius_reg, diam_reg;
    out_t out_reg;
    logic [DistW-1:0] du, e_sel;

    assign du    = dist_reg[cmd.idx];
    assign e_sel = ecc_store[cmd.idx];

    // one lane per destination vertex, relaxing against the row just read
    always_comb begin
        logic [WeightW-1:0] w;
        logic [DistW:0]     s;
        logic [DistW-1:0]   d;
        for (int v = 0; v < NumVert; v++) begin
            w = adj_q_reg[v*WeightW +: WeightW];
            s = {1'b0, du} + {{(DistW+1-WeightW){1'b0}}, w};
            d = (s > {1'b0, DistMax}) ? DistMax : s[DistW-1:0];
            dist_next[v]  = dist_reg[v];
            reach_next[v] = reach_reg[v];
            if (reach_reg[cmd.idx] && (w != '0) && (CountW'(v) < cmd.n) &&
                (!reach_reg[v] || d < dist_reg[v])) begin
                dist_next[v]  = d;
                reach_next[v] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            adj_mem[s_data.row][{s_data.col, 2'b00} +: WeightW] <= s_data.weight;
        end
        if (cmd.rd_en) begin
            adj_q_reg <= adj_mem[cmd.rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            for (int v = 0; v < NumVert; v++) begin
                dist_reg[v] <= '0;
            end
            reach_reg <= NumVert'(1) << cmd.src;
            max_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            if (cmd.relax) begin
                for (int v = 0; v < NumVert; v++) begin
                    dist_reg[v] <= dist_next[v];
                end
                reach_reg <= reach_next;
            end
            if (cmd.red_en && reach_reg[cmd.idx]) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (dist_reg[cmd.idx] > max_reg) begin
                    max_reg <= dist_reg[cmd.idx];
                end
            end
        end
        if (cmd.store) begin
            ecc_store[cmd.src] <= max_reg;
            full_reg[cmd.src]  <= (cnt_reg == cmd.n);
            two_reg[cmd.src]   <= (cnt_reg == CountW'(2));
        end
        if (cmd.sum_clr) begin
            radius_reg <= '0;
            diam_reg   <= '0;
        end else if (cmd.sum_en) begin
            if (e_sel > diam_reg) begin
                diam_reg <= e_sel;
            end
            if (e_sel != '0 && (radius_reg == '0 || e_sel < radius_reg)) begin
                radius_reg <= e_sel;
            end
        end
        if (cmd.emit) begin
            out_reg.vertex        <= cmd.idx;
            out_reg.eccentricity  <= e_sel;
            out_reg.radius        <= radius_reg;
            out_reg.diameter      <= diam_reg;
            out_reg.is_central    <= (e_sel == radius_reg);
            out_reg.is_peripheral <= (e_sel == diam_reg);
            out_reg.is_isolated   <= (e_sel == '0);
            out_reg.reaches_all   <= full_reg[cmd.idx];
            out_reg.reaches_two   <= two_reg[cmd.idx];
            out_reg.last          <= cmd.last;
        end
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

@@ design/gee_ctrl.sv @@
// controller: sequences matrix writes, per-source relaxation, reductions and emission
`default_nettype none
`include "graph_eccentricity_engine_unit_macros.svh"
module gee_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire gee_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire logic         cfg_we,
    input  wire logic [4:0]   cfg_wdata,
    output gee_pkg::cmd_t     cmd
);
    import gee_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_RELAX, S_DRAIN, S_REDUCE, S_STORE, S_SUMMARY, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [CountW-1:0] vc_reg, vc_next;
    logic [VertW-1:0] src_reg, src_next, round_reg, round_next;
    logic [VertW-1:0] u_reg, u_next, u_d_reg, u_d_next, idx_reg, idx_next;
    logic relax_pend_reg, relax_pend_next;
    logic m_valid_reg, m_valid_next;
    logic [CountW-1:0] n_eff;
    logic [VertW-1:0] nm1;
    logic out_free;

    assign n_eff = (vc_reg == '0) ? CountW'(1) :
                   (vc_reg > CountW'(NumVert)) ? CountW'(NumVert) : vc_reg;
    assign nm1      = VertW'(n_eff - 1'b1);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        vc_next         = cfg_we ? cfg_wdata : vc_reg;
        src_next        = src_reg;
        round_next      = round_reg;
        u_next          = u_reg;
        u_d_next        = u_d_reg;
        idx_next        = idx_reg;
        relax_pend_next = 1'b0;
        cmd             = '0;
        cmd.n           = n_eff;
        cmd.src         = src_reg;
        cmd.idx         = idx_reg;
        cmd.rd_row      = u_reg;
        cmd.relax       = relax_pend_reg;
        s_ready         = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == OpWrite) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.sum_clr = 1'b1;
                        src_next    = '0;
                        state_next  = S_INIT;
                    end
                end
            end
            S_INIT: begin
                cmd.init   = 1'b1;
                u_next     = '0;
                round_next = '0;
                state_next = S_RELAX;
            end
            S_RELAX: begin
                // row read issued now, relaxed in the following cycle under u_d
                cmd.idx         = u_d_reg;
                cmd.rd_en       = 1'b1;
                relax_pend_next = 1'b1;
                u_d_next        = u_reg;
                if (u_reg == nm1) begin
                    u_next = '0;
                    if (round_reg == nm1) begin
                        state_next = S_DRAIN;
                    end else begin
                        round_next = round_reg + 1'b1;
                    end
                end else begin
                    u_next = u_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                cmd.idx    = u_d_reg;
                idx_next   = '0;
                state_next = S_REDUCE;
            end
            S_REDUCE: begin
                cmd.red_en = 1'b1;
                if (idx_reg == nm1) begin
                    state_next = S_STORE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                if (src_reg == nm1) begin
                    idx_next   = '0;
                    state_next = S_SUMMARY;
                end else begin
                    src_next   = src_reg + 1'b1;
                    state_next = S_INIT;
                end
            end
            S_SUMMARY: begin
                cmd.sum_en = 1'b1;
                if (idx_reg == nm1) begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    cmd.last = (idx_reg == nm1);
                    if (idx_reg == nm1) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        m_valid_next = cmd.emit | (m_valid_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            vc_reg         <= VcReset;
            src_reg        <= '0;
            round_reg      <= '0;
            u_reg          <= '0;
            u_d_reg        <= '0;
            idx_reg        <= '0;
            relax_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            vc_reg         <= vc_next;
            src_reg        <= src_next;
            round_reg      <= round_next;
            u_reg          <= u_next;
            u_d_reg        <= u_d_next;
            idx_reg        <= idx_next;
            relax_pend_reg <= relax_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    `GEE_ASSERT_IMP(a_emit_free, cmd.emit, !m_valid_reg || m_ready)
    `GEE_ASSERT_NXT(a_read_then_relax, cmd.rd_en, relax_pend_reg)
    `GEE_ASSERT_IMP(a_reduce_in_range, cmd.red_en, {1'b0, idx_reg} < n_eff)
    `GEE_ASSERT_IMP(a_relax_has_read, relax_pend_reg, $past(cmd.rd_en))
endmodule
`default_nettype wire

@@ design/graph_eccentricity_engine_unit.sv @@
// matrix writes are taken back to back while the unit is idle
// compute: per source an init step, n*n row reads, a drain step, a reduction
// over the n vertices and a store; then a summary pass and an emit pass over
// all n vertices, emission waiting on m_ready; one row-relaxation unit is shared
// reset: synchronous active-low aresetn, vertex count returns to 16,
// adjacency memory keeps its contents and is undefined until written
`default_nettype none
module graph_eccentricity_engine_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire gee_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output gee_pkg::out_t      m_data,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_wdata
);
    import gee_pkg::*;

    cmd_t cmd;

    gee_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd)
    );

    gee_dp u_dp (
        .aclk   (aclk),
        .s_data (s_data),
        .cmd    (cmd),
        .m_data (m_data)
    );
endmodule
`default_nettype wire
